// ----- design/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Frame constants, result status codes and sensor type codes.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] FRAME_LEN  = 8'd4;
  localparam logic [3:0] FRAME_SIZE = 4'd8;
  localparam logic [3:0] COUNT_MAX  = 4'd15;

  localparam logic [3:0] IDX_SYNC   = 4'd0;
  localparam logic [3:0] IDX_TYPE   = 4'd1;
  localparam logic [3:0] IDX_LEN    = 4'd2;
  localparam logic [3:0] IDX_DATA0  = 4'd3;
  localparam logic [3:0] IDX_DATA1  = 4'd4;
  localparam logic [3:0] IDX_DATA2  = 4'd5;
  localparam logic [3:0] IDX_DATA3  = 4'd6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_BAD_CSUM  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN  = 2'd0,
    TYPE_TEMP     = 2'd1,
    TYPE_PRESSURE = 2'd2,
    TYPE_HUMIDITY = 2'd3
  } sensor_type_t;

endpackage

// ----- design/spd_if.sv -----
// ----------------------------------------------------------------------------
// Sensor packet deframer channels
// Byte channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface spd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  sensor_type;
  logic [31:0] value_bits;

  modport source (output valid, output status, output sensor_type, output value_bits,
                  input ready);
  modport sink (input valid, input status, input sensor_type, input value_bits,
                output ready);
endinterface

// ----- design/sensor_packet_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Checks and decodes a sync-byte framed sensor packet received one byte
// per beat.
//
// The rx channel carries one byte per beat, with is_last marking the final
// byte of a buffer. The expected frame is the sync byte, a type byte, a
// length byte of four, four data bytes and an additive checksum.
// The result channel carries one beat per buffer, with a status, the
// sensor type and the raw little-endian data word; the type and word are
// zero when the status is not ok.
// A byte is taken every cycle but for the stall below. A buffer's result
// enters an output register when its last byte is taken and is held until it
// is taken. While a result waits and the receiver stalls, rx stays ready
// until another last byte would need that register.
// Reset clears the frame state and drops the result valid.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_unit (
  input  logic         clk,
  input  logic         rst,
  spd_byte_if.sink     rx,
  spd_result_if.source result
);

  logic [3:0]  byte_count;
  logic [7:0]  running_sum;
  logic        header_bad;
  logic        length_bad;
  logic [1:0]  type_code;
  logic [31:0] data_word;

  logic        res_valid;
  logic [2:0]  res_status;
  logic [1:0]  res_type;
  logic [31:0] res_value;

  logic [3:0]  total;
  logic [31:0] data_word_next;
  logic [1:0]  type_code_next;
  logic        accept;
  spd_pkg::status_t status_next;

  assign rx.ready = !res_valid || result.ready || !rx.is_last;
  assign accept   = rx.valid && rx.ready;

  assign total = (byte_count == spd_pkg::COUNT_MAX) ? spd_pkg::COUNT_MAX
                                                    : byte_count + 4'd1;

  always_comb begin
    data_word_next = data_word;
    case (byte_count)
      spd_pkg::IDX_DATA0: data_word_next[7:0]   = rx.data_byte;
      spd_pkg::IDX_DATA1: data_word_next[15:8]  = rx.data_byte;
      spd_pkg::IDX_DATA2: data_word_next[23:16] = rx.data_byte;
      spd_pkg::IDX_DATA3: data_word_next[31:24] = rx.data_byte;
      default: data_word_next = data_word;
    endcase
  end

  always_comb begin
    if (rx.data_byte == 8'd1 || rx.data_byte == 8'd2 || rx.data_byte == 8'd3) begin
      type_code_next = rx.data_byte[1:0];
    end else begin
      type_code_next = spd_pkg::TYPE_UNKNOWN;
    end
  end

  always_comb begin
    if (total < spd_pkg::FRAME_SIZE) begin
      status_next = spd_pkg::ST_SHORT;
    end else if (header_bad) begin
      status_next = spd_pkg::ST_BAD_HDR;
    end else if (length_bad) begin
      status_next = spd_pkg::ST_BAD_LEN;
    end else if (total != spd_pkg::FRAME_SIZE) begin
      status_next = spd_pkg::ST_BAD_SIZE;
    end else if (rx.data_byte != running_sum) begin
      status_next = spd_pkg::ST_BAD_CSUM;
    end else begin
      status_next = spd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 4'd0;
      running_sum <= 8'd0;
      header_bad  <= 1'b0;
      length_bad  <= 1'b0;
      type_code   <= spd_pkg::TYPE_UNKNOWN;
      data_word   <= 32'd0;
    end else if (accept) begin
      if (rx.is_last) begin
        byte_count  <= 4'd0;
        running_sum <= 8'd0;
        header_bad  <= 1'b0;
        length_bad  <= 1'b0;
        type_code   <= spd_pkg::TYPE_UNKNOWN;
        data_word   <= 32'd0;
      end else begin
        byte_count  <= total;
        running_sum <= running_sum + rx.data_byte;
        data_word   <= data_word_next;
        if (byte_count == spd_pkg::IDX_SYNC && rx.data_byte != spd_pkg::SYNC_BYTE) begin
          header_bad <= 1'b1;
        end
        if (byte_count == spd_pkg::IDX_TYPE) begin
          type_code <= type_code_next;
        end
        if (byte_count == spd_pkg::IDX_LEN && rx.data_byte != spd_pkg::FRAME_LEN) begin
          length_bad <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && rx.is_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx.is_last) begin
      res_status <= status_next;
      if (status_next == spd_pkg::ST_OK) begin
        res_type  <= type_code;
        res_value <= data_word;
      end else begin
        res_type  <= spd_pkg::TYPE_UNKNOWN;
        res_value <= 32'd0;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.status      = res_status;
  assign result.sensor_type = res_type;
  assign result.value_bits  = res_value;

endmodule

// ----- design/spd_checker.sv -----
// ----------------------------------------------------------------------------
// Sensor packet deframer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        rx_is_last,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_status,
  input logic [1:0]  res_type,
  input logic [31:0] res_value
);

  // A stalled result beat keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) &&
      $stable(res_type) && $stable(res_value))
    else $error("stalled result beat changed");

  // Every last byte taken yields a result beat in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready && rx_is_last |=> res_valid)
    else $error("last byte gave no result");

  // A result beat only appears after a last byte.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_valid && rx_ready && rx_is_last))
    else $error("result without a last byte");

  // A failed frame reports neither a type nor a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != spd_pkg::ST_OK |->
      res_type == spd_pkg::TYPE_UNKNOWN && res_value == 32'd0)
    else $error("failed frame carries data");

endmodule

bind sensor_packet_deframer_unit spd_checker u_spd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx.valid),
  .rx_ready   (rx.ready),
  .rx_is_last (rx.is_last),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_type   (result.sensor_type),
  .res_value  (result.value_bits)
);

// ----- verif/sensor_packet_deframer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor packet deframer testbench
// Streams framed and corrupted byte buffers into the deframer and checks
// every result beat against a cycle-free model of the frame checks. Both
// channels stall at random in two mixed phases before a final phase in
// which neither side holds back.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int TARGET_BEATS = 900;
  localparam int SENDER_IDLE[3] = '{37, 65, 0};
  localparam int RECEIVER_IDLE[3] = '{65, 37, 0};

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] data_byte;
    logic       is_last;
  } rx_beat_t;

  typedef struct {
    spd_pkg::status_t      status;
    spd_pkg::sensor_type_t sensor_type;
    logic [31:0]           value_bits;
  } reading_t;

  logic clk;
  logic rst;

  spd_byte_if   rx_ch ();
  spd_result_if res_ch ();

  sensor_packet_deframer_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  rx_beat_t     pending_beats[$];
  reading_t     expected_readings[$];
  int           total_beats = 0;
  int           sent_count = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  logic [3:0]            frame_count = '0;
  logic [7:0]            frame_sum = '0;
  logic                  hdr_err = 1'b0;
  logic                  len_err = 1'b0;
  spd_pkg::sensor_type_t frame_type = spd_pkg::TYPE_UNKNOWN;
  logic [31:0]           frame_word = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int run_phase();
    if (sent_count * 3 < total_beats) return 0;
    else if (sent_count * 3 < total_beats * 2) return 1;
    return 2;
  endfunction

  function automatic void deframe_byte(input logic [7:0] rx_byte, input logic rx_last);
    logic [3:0] idx;
    logic [3:0] total;
    reading_t   reading;
    idx = frame_count;
    if (idx == spd_pkg::IDX_SYNC && rx_byte != spd_pkg::SYNC_BYTE) hdr_err = 1'b1;
    if (idx == spd_pkg::IDX_TYPE) begin
      if (rx_byte[7:2] == 6'd0 && rx_byte[1:0] != spd_pkg::TYPE_UNKNOWN)
        frame_type = spd_pkg::sensor_type_t'(rx_byte[1:0]);
      else
        frame_type = spd_pkg::TYPE_UNKNOWN;
    end
    if (idx == spd_pkg::IDX_LEN && rx_byte != spd_pkg::FRAME_LEN) len_err = 1'b1;
    if (idx >= spd_pkg::IDX_DATA0 && idx <= spd_pkg::IDX_DATA3)
      frame_word = frame_word | ({24'd0, rx_byte} << (8 * (idx - spd_pkg::IDX_DATA0)));
    total = (idx < spd_pkg::COUNT_MAX) ? idx + 4'd1 : spd_pkg::COUNT_MAX;
    if (!rx_last) begin
      frame_sum = frame_sum + rx_byte;
      frame_count = total;
      return;
    end
    if (total < spd_pkg::FRAME_SIZE) reading.status = spd_pkg::ST_SHORT;
    else if (hdr_err) reading.status = spd_pkg::ST_BAD_HDR;
    else if (len_err) reading.status = spd_pkg::ST_BAD_LEN;
    else if (total != spd_pkg::FRAME_SIZE) reading.status = spd_pkg::ST_BAD_SIZE;
    else if (rx_byte != frame_sum) reading.status = spd_pkg::ST_BAD_CSUM;
    else reading.status = spd_pkg::ST_OK;
    reading.sensor_type = (reading.status == spd_pkg::ST_OK) ? frame_type
                                                             : spd_pkg::TYPE_UNKNOWN;
    reading.value_bits = (reading.status == spd_pkg::ST_OK) ? frame_word : 32'd0;
    expected_readings = {expected_readings, reading};
    frame_count = '0;
    frame_sum = '0;
    hdr_err = 1'b0;
    len_err = 1'b0;
    frame_type = spd_pkg::TYPE_UNKNOWN;
    frame_word = '0;
  endfunction

  function automatic byte_q_t frame_body(input logic [7:0] ftype, input logic [31:0] word);
    byte_q_t body;
    body = {spd_pkg::SYNC_BYTE, ftype, spd_pkg::FRAME_LEN,
            word[7:0], word[15:8], word[23:16], word[31:24]};
    return body;
  endfunction

  // A sealed buffer gets a checksum byte appended, optionally spoilt by sum_flip.
  function automatic void queue_buffer(input byte_q_t body, input logic seal,
                                       input logic [7:0] sum_flip);
    logic [7:0] sum;
    rx_beat_t   beat;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    if (seal) body = {body, sum ^ sum_flip};
    foreach (body[i]) begin
      beat.data_byte = body[i];
      beat.is_last = (i == body.size() - 1);
      pending_beats = {pending_beats, beat};
    end
  endfunction

  always @(posedge clk) begin : drive_rx
    rx_beat_t beat;
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.data_byte, rx_ch.is_last);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= SENDER_IDLE[run_phase()]) begin
          beat = pending_beats.pop_front();
          rx_ch.valid <= 1'b1;
          rx_ch.data_byte <= beat.data_byte;
          rx_ch.is_last <= beat.is_last;
          sent_count++;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= RECEIVER_IDLE[run_phase()]);
    end
  end

  always @(posedge clk) begin : check_result
    reading_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result beat at cycle %0d: status %0d type %0d value %h",
                   cycle_count, res_ch.status, res_ch.sensor_type, res_ch.value_bits);
      end else begin
        want = expected_readings.pop_front();
        if (res_ch.status !== want.status || res_ch.sensor_type !== want.sensor_type ||
            res_ch.value_bits !== want.value_bits) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch at cycle %0d: expected %0d/%0d/%h, got %0d/%0d/%h",
                     cycle_count, want.status, want.sensor_type, want.value_bits,
                     res_ch.status, res_ch.sensor_type, res_ch.value_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    byte_q_t body;
    int      kind;
    int      n;
    clk = 1'b0;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.data_byte = '0;
    rx_ch.is_last = 1'b0;
    res_ch.ready = 1'b0;

    body = {};
    body = {body, 8'hFF};
    queue_buffer(body, 1'b0, 8'h00);
    queue_buffer(frame_body(8'h03, 32'hFFFF_FFFF), 1'b1, 8'h00);
    body = frame_body(8'h80, 32'h0000_0000);
    body = {body, 8'h55};
    queue_buffer(body, 1'b1, 8'h00);
    body = frame_body(8'h01, 32'h3F80_0000);
    body[0] = 8'h00;
    body.delete(6);
    queue_buffer(body, 1'b0, 8'h00);

    while (pending_beats.size() < TARGET_BEATS) begin
      kind = $urandom_range(99);
      if ($urandom_range(3) != 0)
        body = frame_body(8'($urandom_range(1, 3)), $urandom);
      else
        body = frame_body(8'($urandom_range(255)), $urandom);
      if (kind < 55) begin
        queue_buffer(body, 1'b1, 8'h00);
      end else if (kind < 63) begin
        body[0] = 8'($urandom_range(255));
        queue_buffer(body, 1'b1, 8'h00);
      end else if (kind < 71) begin
        body[2] = 8'($urandom_range(255));
        queue_buffer(body, 1'b1, 8'h00);
      end else if (kind < 79) begin
        queue_buffer(body, 1'b1, 8'($urandom_range(1, 255)));
      end else if (kind < 87) begin
        n = $urandom_range(0, 6);
        while (body.size() > n + 1) void'(body.pop_back());
        queue_buffer(body, 1'b0, 8'h00);
      end else if (kind < 95) begin
        n = $urandom_range(1, 12);
        repeat (n) body = {body, 8'($urandom_range(255))};
        queue_buffer(body, 1'b1, 8'h00);
      end else begin
        body = {};
        n = $urandom_range(1, 20);
        repeat (n) body = {body, 8'($urandom_range(255))};
        queue_buffer(body, 1'b0, 8'h00);
      end
    end
    total_beats = pending_beats.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || rx_ch.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
